FILE: hw/rtl/assert_macros.svh
// Assertion helpers, included by the top-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, suspended while reset is asserted.
`define GTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define GTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gtc_pkg.sv
`timescale 1ns / 1ps

package gtc_pkg;

  // Field widths of the transaction ports and the number of colours
  localparam int IDX_W       = 6;
  localparam int ROW_W       = 64;
  localparam int CNT_W       = 7;
  localparam int NUM_COLOURS = 3;

  // Colour codes; the last code marks an uncoloured vertex
  typedef logic [1:0] colour_t;
  localparam colour_t COLOUR_0  = 2'd0;
  localparam colour_t COLOUR_1  = 2'd1;
  localparam colour_t COLOUR_2  = 2'd2;
  localparam colour_t NO_COLOUR = 2'd3;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_FWD,
    S_NBR,
    S_TRY,
    S_BACK,
    S_OUT
  } state_e;

  // Ignored edge of a query
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] u;
    logic [IDX_W-1:0] v;
  } skip_t;

endpackage

FILE: hw/rtl/gtc_row_ram.sv
`timescale 1ns / 1ps

module gtc_row_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;

  // Write one row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Mark rows written since reset; unwritten rows read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/gtc_nbr_mask.sv
`timescale 1ns / 1ps

module gtc_nbr_mask #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         row_a_i,
  input  logic [WIDTH-1:0]         row_t_i,
  input  logic [WIDTH-1:0]         active_i,
  input  logic [$clog2(WIDTH)-1:0] vertex_i,
  input  gtc_pkg::skip_t           skip_i,
  output logic [WIDTH-1:0]         nbr_o
);

  localparam int VW = $clog2(WIDTH);
  localparam int IW = gtc_pkg::IDX_W;

  logic [IW-1:0] vid;

  assign vid = IW'(vertex_i);

  // Merge row and column, keep active vertices, drop self loop and ignored edge
  always_comb begin
    for (int k = 0; k < WIDTH; k++) begin
      nbr_o[k] = (row_a_i[k] | row_t_i[k]) & active_i[k] & (VW'(k) != vertex_i)
               & ~(skip_i.valid & (((vid == skip_i.u) && (IW'(k) == skip_i.v)) ||
                                   ((vid == skip_i.v) && (IW'(k) == skip_i.u))));
    end
  end

endmodule

FILE: hw/rtl/gtc_colour_check.sv
`timescale 1ns / 1ps

module gtc_colour_check #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]                          nbr_i,
  input  logic [gtc_pkg::NUM_COLOURS-1:0][WIDTH-1:0] cmask_i,
  input  gtc_pkg::colour_t                          colour_i,
  output logic                                      conflict_o
);

  logic [WIDTH-1:0] sel;

  // Select the class of the colour under trial
  always_comb begin
    case (colour_i)
      gtc_pkg::COLOUR_0: sel = cmask_i[0];
      gtc_pkg::COLOUR_1: sel = cmask_i[1];
      gtc_pkg::COLOUR_2: sel = cmask_i[2];
      default:           sel = '0;
    endcase
  end

  // Flag any neighbour already holding that colour
  assign conflict_o = |(nbr_i & sel);

endmodule

FILE: hw/rtl/graph_three_colouring_check.sv
`timescale 1ns / 1ps

// Graph three-colouring checker. A load transaction (req_type 0) writes one adjacency
// row; it is followed by a read-modify-write sweep of a transposed copy, so the block
// is busy while the sweep reads and then writes back each transposed row in turn.
// A query transaction (req_type 1) deletes the masked vertices and, optionally, one
// edge, then runs a depth-first backtracking search over the active vertices in index
// order, trying colours 0, 1, 2 per vertex against one shared neighbour-colour check.
// A query's run time is data-dependent and grows with the number of backtracks.
// One result per query, none per load. Edges count in either row direction; self
// loops and vertices at or beyond vertex_count are ignored. Row storage clears at
// reset through per-row valid bits, with no clearing pass. Write vertex_count only
// while the block is idle.
module graph_three_colouring_check #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gtc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [gtc_pkg::IDX_W-1:0] row_index_i,
  input  logic [gtc_pkg::ROW_W-1:0] row_bits_i,
  input  logic [gtc_pkg::ROW_W-1:0] removed_mask_i,
  input  logic                      skip_valid_i,
  input  logic [gtc_pkg::IDX_W-1:0] skip_u_i,
  input  logic [gtc_pkg::IDX_W-1:0] skip_v_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      colourable_o
);

`include "assert_macros.svh"

  localparam int                NV     = MAX_VERTICES;
  localparam int                VW     = $clog2(NV);
  localparam int                CW     = gtc_pkg::CNT_W;
  localparam int                NC     = gtc_pkg::NUM_COLOURS;
  localparam logic [VW-1:0]     LAST_V = VW'(NV - 1);

  gtc_pkg::state_e               state_q, state_d;
  logic [VW-1:0]                 v_q, v_d;
  logic [VW-1:0]                 r_q, r_d;
  logic [NV-1:0]                 row_q, row_d;
  logic [NV-1:0]                 active_q, active_d;
  gtc_pkg::skip_t                skip_q, skip_d;
  logic [NC-1:0][NV-1:0]         cmask_q, cmask_d;
  gtc_pkg::colour_t              c_q, c_d;
  logic [NV-1:0]                 nb_q, nb_d;
  logic                          res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  logic                          colourable_q, colourable_d;
  logic [CW-1:0]                 vcount_q, vcount_d;

  logic                          a_we;
  logic [NV-1:0]                 a_rdata;
  logic                          t_we;
  logic [NV-1:0]                 t_wdata;
  logic [NV-1:0]                 t_rdata;
  logic [NV-1:0]                 act_new;
  logic [NV-1:0]                 nb_w;
  logic                          conflict_w;
  gtc_pkg::colour_t              cur;

  // Adjacency rows as loaded
  gtc_row_ram #(
    .DEPTH (NV),
    .WIDTH (NV)
  ) u_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (a_we),
    .waddr_i (row_index_i[VW-1:0]),
    .wdata_i (row_bits_i[NV-1:0]),
    .raddr_i (v_q),
    .rdata_o (a_rdata)
  );

  // Transposed copy: row k holds column k of the loaded rows
  gtc_row_ram #(
    .DEPTH (NV),
    .WIDTH (NV)
  ) u_cols (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (t_we),
    .waddr_i (v_q),
    .wdata_i (t_wdata),
    .raddr_i (v_q),
    .rdata_o (t_rdata)
  );

  // Neighbours of the vertex under the cursor
  gtc_nbr_mask #(
    .WIDTH (NV)
  ) u_nbr (
    .row_a_i  (a_rdata),
    .row_t_i  (t_rdata),
    .active_i (active_q),
    .vertex_i (v_q),
    .skip_i   (skip_q),
    .nbr_o    (nb_w)
  );

  // Shared neighbour-colour conflict check
  gtc_colour_check #(
    .WIDTH (NV)
  ) u_check (
    .nbr_i      (nb_q),
    .cmask_i    (cmask_q),
    .colour_i   (c_q),
    .conflict_o (conflict_w)
  );

  // Replace bit r of transposed row v with bit v of the new row
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      t_wdata[i] = (VW'(i) == r_q) ? row_q[v_q] : t_rdata[i];
    end
  end

  // Active vertices of a new query
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      act_new[i] = (CW'(i) < vcount_q) & ~removed_mask_i[i];
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      active_q    <= '0;
      cmask_q     <= '0;
      c_q         <= gtc_pkg::NO_COLOUR;
      out_valid_q <= 1'b0;
      vcount_q    <= '0;
    end else begin
      v_q         <= v_d;
      active_q    <= active_d;
      cmask_q     <= cmask_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
      vcount_q    <= vcount_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_q          <= r_d;
    row_q        <= row_d;
    skip_q       <= skip_d;
    nb_q         <= nb_d;
    res_q        <= res_d;
    colourable_q <= colourable_d;
  end

  // Sequencer: load sweep and backtracking search
  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    r_d          = r_q;
    row_d        = row_q;
    active_d     = active_q;
    skip_d       = skip_q;
    cmask_d      = cmask_q;
    c_d          = c_q;
    nb_d         = nb_q;
    res_d        = res_q;
    colourable_d = colourable_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    vcount_d     = cfg_we_i ? cfg_wdata_i : vcount_q;
    a_we         = 1'b0;
    t_we         = 1'b0;
    cur          = gtc_pkg::NO_COLOUR;

    unique case (state_q)
      gtc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == gtc_pkg::REQ_LOAD) begin
            // Drop loads beyond the row store
            if ({1'b0, row_index_i} < CW'(NV)) begin
              a_we    = 1'b1;
              r_d     = row_index_i[VW-1:0];
              row_d   = row_bits_i[NV-1:0];
              v_d     = '0;
              state_d = gtc_pkg::S_LD_RD;
            end
          end else begin
            active_d = act_new;
            skip_d   = '{valid: skip_valid_i, u: skip_u_i, v: skip_v_i};
            cmask_d  = '0;
            v_d      = '0;
            state_d  = gtc_pkg::S_FWD;
          end
        end
      end
      gtc_pkg::S_LD_RD: begin
        state_d = gtc_pkg::S_LD_WR;
      end
      gtc_pkg::S_LD_WR: begin
        t_we = 1'b1;
        if (v_q == LAST_V) begin
          state_d = gtc_pkg::S_IDLE;
        end else begin
          v_d     = v_q + VW'(1);
          state_d = gtc_pkg::S_LD_RD;
        end
      end
      gtc_pkg::S_FWD: begin
        // Advance to the next active vertex; past the last one the graph is coloured
        if (active_q[v_q]) begin
          state_d = gtc_pkg::S_NBR;
        end else if (v_q == LAST_V) begin
          res_d   = 1'b1;
          state_d = gtc_pkg::S_OUT;
        end else begin
          v_d = v_q + VW'(1);
        end
      end
      gtc_pkg::S_NBR: begin
        // Latch neighbours, uncolour the vertex and resume after its old colour
        nb_d = nb_w;
        for (int c = 0; c < NC; c++) begin
          if (cmask_q[c][v_q]) begin
            cur           = gtc_pkg::colour_t'(c);
            cmask_d[c][v_q] = 1'b0;
          end
        end
        c_d     = (cur == gtc_pkg::NO_COLOUR) ? gtc_pkg::COLOUR_0 : cur + 2'd1;
        state_d = gtc_pkg::S_TRY;
      end
      gtc_pkg::S_TRY: begin
        if (c_q == gtc_pkg::NO_COLOUR) begin
          // Colours exhausted: back up
          if (v_q == '0) begin
            res_d   = 1'b0;
            state_d = gtc_pkg::S_OUT;
          end else begin
            v_d     = v_q - VW'(1);
            state_d = gtc_pkg::S_BACK;
          end
        end else if (conflict_w) begin
          c_d = c_q + 2'd1;
        end else begin
          cmask_d[c_q][v_q] = 1'b1;
          if (v_q == LAST_V) begin
            res_d   = 1'b1;
            state_d = gtc_pkg::S_OUT;
          end else begin
            v_d     = v_q + VW'(1);
            state_d = gtc_pkg::S_FWD;
          end
        end
      end
      gtc_pkg::S_BACK: begin
        // Retreat to the previous active vertex; none left means no colouring
        if (active_q[v_q]) begin
          state_d = gtc_pkg::S_NBR;
        end else if (v_q == '0) begin
          res_d   = 1'b0;
          state_d = gtc_pkg::S_OUT;
        end else begin
          v_d = v_q - VW'(1);
        end
      end
      gtc_pkg::S_OUT: begin
        // Hold the answer until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          colourable_d = res_q;
          state_d      = gtc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gtc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready_o   = (state_q == gtc_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign colourable_o = colourable_q;

  // The vertex under the cursor belongs to at most one colour class
  `GTC_ASSERT(a_one_colour, clk_i, rst_ni, $onehot0({cmask_q[2][v_q], cmask_q[1][v_q], cmask_q[0][v_q]}), "vertex holds two colours")

  // Only active vertices are ever coloured
  `GTC_ASSERT(a_coloured_active, clk_i, rst_ni, ((cmask_q[0] | cmask_q[1] | cmask_q[2]) & ~active_q) == '0, "inactive vertex coloured")

  // A finished answer waits while the previous one is not taken
  `GTC_ASSERT(a_out_wait, clk_i, rst_ni, (state_q == gtc_pkg::S_OUT) && out_valid_q && !out_ready_i |=> (state_q == gtc_pkg::S_OUT), "answer dropped")

endmodule
